// ===== hw/rtl/slrg_pkg.sv =====
package slrg_pkg;

    // Seed and output word
    localparam int SEED_W = 31;
    typedef logic [SEED_W-1:0] seed_t;

    // Lehmer constants: multiplier 16807, modulus 2^31 - 1
    localparam int    MUL_W    = 15;
    localparam int    PROD_W   = SEED_W + MUL_W;
    localparam seed_t LEH_MOD  = seed_t'(2147483647);
    localparam logic [MUL_W-1:0] LEH_MUL = MUL_W'(16807);
    localparam seed_t SEED_RST = seed_t'(50);
    localparam seed_t SEED_ONE = seed_t'(1);

    // Shuffle table geometry (depth is a power of two)
    localparam int TBL_AW     = 5;
    localparam int TBL_DEPTH  = 1 << TBL_AW;
    localparam int LOW_W      = SEED_W - TBL_AW;
    localparam int WARM_STEPS = TBL_DEPTH + 8;
    localparam int CNT_W      = $clog2(WARM_STEPS + 1);

    typedef logic [TBL_AW-1:0] tbl_addr_t;
    typedef logic [CNT_W-1:0]  step_cnt_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_WMUL,
        ST_WFOLD,
        ST_AMUL,
        ST_AFOLD
    } state_t;

    // floor(held * N / (N + 2^31 - 2)) with N = 2^TBL_AW.
    // The estimate held >> LOW_W is exact or one too large; one compare settles it.
    function automatic tbl_addr_t shuffle_index(input seed_t held);
        tbl_addr_t           q0;
        logic [2*TBL_AW-1:0] lhs;
        seed_t               rhs;
        q0  = held[SEED_W-1 -: TBL_AW];
        lhs = (2*TBL_AW)'(q0) * (2*TBL_AW)'(TBL_DEPTH - 2);
        rhs = {held[LOW_W-1:0], {TBL_AW{1'b0}}};
        if (SEED_W'(lhs) <= rhs)
        begin
            return q0;
        end
        return q0 - 1'b1;
    endfunction

    // Zero and the modulus itself would stick at zero: take them as one
    function automatic seed_t seed_clean(input seed_t s);
        if (s == '0 || s == LEH_MOD)
        begin
            return SEED_ONE;
        end
        return s;
    endfunction

endpackage

// ===== hw/rtl/slrg_ram.sv =====
module slrg_ram #(
    parameter int WIDTH = 31,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ===== hw/rtl/slrg_lehmer.sv =====
module slrg_lehmer (
    input  logic           clk,
    input  logic           load,
    input  slrg_pkg::seed_t seed,
    output slrg_pkg::seed_t next_seed
);
    import slrg_pkg::*;

    logic [PROD_W-1:0] prod_reg;
    logic [SEED_W:0]   fold_sum;

    // Register the product seed * 16807
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            prod_reg <= PROD_W'(seed) * PROD_W'(LEH_MUL);
        end
    end

    // Fold modulo 2^31 - 1: high part plus low part, one subtract
    always_comb
    begin
        fold_sum = (SEED_W+1)'(prod_reg[PROD_W-1:SEED_W])
                 + (SEED_W+1)'(prod_reg[SEED_W-1:0]);
        if (fold_sum >= (SEED_W+1)'(LEH_MOD))
        begin
            next_seed = SEED_W'(fold_sum - (SEED_W+1)'(LEH_MOD));
        end
        else
        begin
            next_seed = fold_sum[SEED_W-1:0];
        end
    end

endmodule

// ===== hw/rtl/shuffled_lehmer_random_generator.sv =====
// Shuffled Lehmer random generator: minimal-standard Lehmer sequence
// (x' = 16807 x mod 2^31-1) read through a 32-entry shuffle table.
// Request channel: start with command and seed_value, taken when busy is low.
// command 0 asks for the next number, command 1 reseeds from seed_value
// (zero or the modulus taken as one) and then gives a number.
// Result channel: random_value is shown for one cycle with valid high.
// A next-number request passes a multiply state and then a fold state,
// and its result is shown in the fold state; busy drops in that result
// cycle, so a new request can be taken alongside each result. Each Lehmer
// step has a multiply state and a fold state; the table read in the
// multiply state and the write-back in the fold state share one memory.
// A reseed first adds 40 warm-up steps, each a multiply and a fold.
// After reset the stored seed is 50 and the first request reseeds whatever its
// command (command 0 from that seed). The table itself is not cleared by reset.
// The receiver cannot stall: every result must be taken in its valid cycle.
module shuffled_lehmer_random_generator (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            start,
    output logic            busy,
    input  logic            command,
    input  slrg_pkg::seed_t seed_value,
    output logic            valid,
    output slrg_pkg::seed_t random_value
);
    import slrg_pkg::*;

    state_t    state_reg, state_next;
    step_cnt_t cnt_reg, cnt_next;
    seed_t     seed_reg, seed_next;
    seed_t     held_reg, held_next;

    logic      accept;
    logic      reseed_req;
    seed_t     held_live;
    seed_t     step_val;
    seed_t     rd_data;
    logic      lehmer_load;
    logic      tbl_we;
    tbl_addr_t tbl_waddr;
    seed_t     tbl_wdata;
    logic      tbl_re;
    tbl_addr_t tbl_raddr;
    step_cnt_t cnt_dec;

    slrg_lehmer u_lehmer (
        .clk       (clk),
        .load      (lehmer_load),
        .seed      (seed_reg),
        .next_seed (step_val)
    );

    slrg_ram #(
        .WIDTH (SEED_W),
        .DEPTH (TBL_DEPTH)
    ) u_table (
        .clk   (clk),
        .we    (tbl_we),
        .waddr (tbl_waddr),
        .wdata (tbl_wdata),
        .re    (tbl_re),
        .raddr (tbl_raddr),
        .rdata (rd_data)
    );

    // Request acceptance; held value as it stands after this cycle's update
    always_comb
    begin
        accept     = start && !busy;
        held_live  = (state_reg == ST_AFOLD) ? rd_data : held_reg;
        reseed_req = command || (held_live == '0);
        cnt_dec    = cnt_reg - 1'b1;
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = reseed_req ? ST_WMUL : ST_AMUL;
                end
            end
            ST_WMUL:
            begin
                state_next = ST_WFOLD;
            end
            ST_WFOLD:
            begin
                state_next = (cnt_reg == step_cnt_t'(1)) ? ST_AMUL : ST_WMUL;
            end
            ST_AMUL:
            begin
                state_next = ST_AFOLD;
            end
            ST_AFOLD:
            begin
                if (accept)
                begin
                    state_next = reseed_req ? ST_WMUL : ST_AMUL;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Outputs and memory controls
    always_comb
    begin
        busy        = 1'b1;
        valid       = 1'b0;
        lehmer_load = 1'b0;
        tbl_we      = 1'b0;
        tbl_waddr   = cnt_dec[TBL_AW-1:0];
        tbl_wdata   = step_val;
        tbl_re      = 1'b0;
        tbl_raddr   = shuffle_index(held_reg);
        case (state_reg)
            ST_IDLE:
            begin
                busy = 1'b0;
            end
            ST_WMUL:
            begin
                lehmer_load = 1'b1;
            end
            ST_WFOLD:
            begin
                tbl_we = (cnt_reg <= step_cnt_t'(TBL_DEPTH));
            end
            ST_AMUL:
            begin
                lehmer_load = 1'b1;
                tbl_re      = 1'b1;
            end
            ST_AFOLD:
            begin
                busy      = 1'b0;
                valid     = 1'b1;
                tbl_we    = 1'b1;
                tbl_waddr = shuffle_index(held_reg);
            end
            default:
            begin
                busy = 1'b1;
            end
        endcase
    end

    assign random_value = rd_data;

    // Seed, held value and warm-up count
    always_comb
    begin
        seed_next = seed_reg;
        held_next = held_reg;
        cnt_next  = cnt_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept && reseed_req)
                begin
                    seed_next = seed_clean(command ? seed_value : seed_reg);
                    cnt_next  = step_cnt_t'(WARM_STEPS);
                end
            end
            ST_WFOLD:
            begin
                seed_next = step_val;
                cnt_next  = cnt_dec;
                if (cnt_reg == step_cnt_t'(1))
                begin
                    held_next = step_val;
                end
            end
            ST_AFOLD:
            begin
                held_next = rd_data;
                seed_next = step_val;
                if (accept && reseed_req)
                begin
                    seed_next = seed_clean(seed_value);
                    cnt_next  = step_cnt_t'(WARM_STEPS);
                end
            end
            default:
            begin
                seed_next = seed_reg;
            end
        endcase
    end

    // Hold control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
            seed_reg  <= SEED_RST;
            held_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            seed_reg  <= seed_next;
            held_reg  <= held_next;
        end
    end

endmodule

// ===== tb/slrg_checker.sv =====
`timescale 1ns / 1ps

// Request codes shared by the stimulus and the checker
package slrg_tb_pkg;

    localparam logic CMD_NEXT   = 1'b0;
    localparam logic CMD_RESEED = 1'b1;

endpackage

module slrg_checker (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            start,
    input  logic            busy,
    input  logic            command,
    input  slrg_pkg::seed_t seed_value,
    input  logic            valid,
    input  slrg_pkg::seed_t random_value,
    output int              fail_count,
    output int              outstanding
);

    import slrg_pkg::*;
    import slrg_tb_pkg::*;

    // Schrage factorisation of the modulus: m = q * a + r
    localparam longint SCHRAGE_Q = 127773;
    localparam longint SCHRAGE_R = 2836;
    localparam longint MODULUS   = 2147483647;
    localparam int     MAX_SHOWN = 10;

    // Mirror of the generator state
    seed_t lehmer_seed;
    seed_t held_number;
    seed_t shuffle_slots [TBL_DEPTH];

    // Numbers still due from the block, oldest first
    seed_t due_numbers [$];

    // One minimal-standard step without overflow
    function automatic seed_t lehmer_advance(input seed_t s);
        longint hi;
        longint lo;
        longint v;
        hi = longint'(s) / SCHRAGE_Q;
        lo = longint'(s) - hi * SCHRAGE_Q;
        v  = longint'(LEH_MUL) * lo - SCHRAGE_R * hi;
        if (v <= 0)
        begin
            v = v + MODULUS;
        end
        return seed_t'(v);
    endfunction

    // Warm the generator up and fill the table from the top entry down
    task automatic warm_up(input seed_t value);
        seed_t s;
        s = value;
        if (s == '0 || s == LEH_MOD)
        begin
            s = SEED_ONE;
        end
        for (int step = TBL_DEPTH + 8; step >= 1; step--)
        begin
            s = lehmer_advance(s);
            if (step <= TBL_DEPTH)
            begin
                shuffle_slots[step-1] = s;
            end
        end
        lehmer_seed = s;
        held_number = shuffle_slots[0];
    endtask

    // Work out the number that one request yields and update the mirror
    task automatic predict_number(input logic cmd, input seed_t new_seed, output seed_t number);
        longint slot;
        if (cmd == CMD_RESEED)
        begin
            warm_up(new_seed);
        end
        else if (held_number == '0)
        begin
            warm_up(lehmer_seed);
        end
        lehmer_seed = lehmer_advance(lehmer_seed);
        slot = (longint'(held_number) * TBL_DEPTH) / (TBL_DEPTH + MODULUS - 1);
        if (slot >= TBL_DEPTH)
        begin
            slot = TBL_DEPTH - 1;
        end
        held_number         = shuffle_slots[slot];
        shuffle_slots[slot] = lehmer_seed;
        number              = held_number;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        seed_t number;
        seed_t wanted;
        if (!rst_n)
        begin
            lehmer_seed = SEED_RST;
            held_number = '0;
            due_numbers.delete();
            fail_count  <= 0;
            outstanding <= 0;
        end
        else
        begin
            // Compare a result against the oldest prediction
            if (valid)
            begin
                if (due_numbers.size() == 0)
                begin
                    if (fail_count < MAX_SHOWN)
                    begin
                        $display("checker: result %0d with no request waiting", random_value);
                    end
                    fail_count <= fail_count + 1;
                end
                else
                begin
                    wanted = due_numbers.pop_front();
                    if (random_value !== wanted)
                    begin
                        if (fail_count < MAX_SHOWN)
                        begin
                            $display("checker: random_value expected %0d got %0d",
                                     wanted, random_value);
                        end
                        fail_count <= fail_count + 1;
                    end
                end
            end
            // Predict the result of a request taken at this edge
            if (start && !busy)
            begin
                predict_number(command, seed_value, number);
                due_numbers.push_back(number);
            end
            outstanding <= due_numbers.size();
        end
    end

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;

    import slrg_pkg::*;
    import slrg_tb_pkg::*;

    localparam int RANDOM_REQUESTS = 1500;
    localparam int CYCLE_LIMIT     = 1000000;
    localparam int DRAIN_LIMIT     = 2000;
    localparam int SETTLE_CYCLES   = 100;

    logic  clk        = 1'b0;
    logic  rst_n      = 1'b0;
    logic  start      = 1'b0;
    logic  command    = CMD_NEXT;
    seed_t seed_value = '0;
    logic  busy;
    logic  valid;
    seed_t random_value;
    int    fail_count;
    int    outstanding;
    int    cycle_count = 0;

    shuffled_lehmer_random_generator dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .command      (command),
        .seed_value   (seed_value),
        .valid        (valid),
        .random_value (random_value)
    );

    slrg_checker u_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .command      (command),
        .seed_value   (seed_value),
        .valid        (valid),
        .random_value (random_value),
        .fail_count   (fail_count),
        .outstanding  (outstanding)
    );

    initial
    begin
        forever #1 clk = ~clk;
    end

    // Abort a hung run
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("tb_top: FAIL");
            $finish;
        end
    end

    // Present a request after an optional gap and hold it until taken
    task automatic issue(input logic cmd, input seed_t new_seed, input int gap);
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start      <= 1'b1;
        command    <= cmd;
        seed_value <= new_seed;
        @(posedge clk);
        while (busy)
        begin
            @(posedge clk);
        end
    endtask

    // Hold off until every predicted number has come back
    task automatic drain();
        int waited;
        waited = 0;
        start <= 1'b0;
        @(posedge clk);
        while (outstanding != 0 && waited < DRAIN_LIMIT)
        begin
            @(posedge clk);
            waited++;
        end
    endtask

    // Seeds biased towards the awkward values
    function automatic seed_t pick_seed();
        case ($urandom_range(0, 9))
            0: return '0;
            1: return LEH_MOD;
            2: return SEED_ONE;
            3: return LEH_MOD - SEED_ONE;
            default: return seed_t'($urandom);
        endcase
    endfunction

    initial
    begin
        int    burst_left;
        int    gap;
        logic  cmd;

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // First request after reset warms up from the stored seed
        issue(CMD_NEXT, seed_t'($urandom), 0);
        issue(CMD_NEXT, '0, 0);
        issue(CMD_NEXT, LEH_MOD, 3);
        // Zero and the modulus both fall back to one
        issue(CMD_RESEED, '0, 0);
        issue(CMD_NEXT, '0, 0);
        issue(CMD_RESEED, LEH_MOD, 1);
        issue(CMD_NEXT, LEH_MOD, 0);
        issue(CMD_RESEED, SEED_ONE, 0);
        issue(CMD_NEXT, '0, 2);
        issue(CMD_RESEED, LEH_MOD - SEED_ONE, 0);
        issue(CMD_NEXT, '0, 0);
        issue(CMD_RESEED, seed_t'(31'h5555_5555), 0);
        issue(CMD_RESEED, seed_t'(31'h2AAA_AAAA), 5);
        issue(CMD_RESEED, SEED_RST, 0);
        for (int i = 0; i < 8; i++)
        begin
            issue(CMD_NEXT, seed_t'($urandom), 0);
        end
        drain();

        // Random bursts, mostly next-number requests
        burst_left = 0;
        for (int i = 0; i < RANDOM_REQUESTS; i++)
        begin
            if (i == RANDOM_REQUESTS / 2)
            begin
                drain();
            end
            if (burst_left == 0)
            begin
                gap        = $urandom_range(1, 12);
                burst_left = $urandom_range(1, 40);
            end
            else
            begin
                gap = 0;
            end
            burst_left--;
            cmd = ($urandom_range(0, 11) == 0) ? CMD_RESEED : CMD_NEXT;
            issue(cmd, pick_seed(), gap);
        end

        drain();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (fail_count == 0 && outstanding == 0)
        begin
            $display("tb_top: PASS");
        end
        else
        begin
            $display("tb_top: FAIL");
        end
        $finish;
    end

endmodule
